// File: hw/rtl/qdc_pkg.sv
// ----------------------------------------------------------------------------
// qdc_pkg
// Shared types, codes and the 4x quadrature table of the detent counter.
// ----------------------------------------------------------------------------
package qdc_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned CntW  = 8;
  localparam int unsigned PpdW  = 7;
  localparam int unsigned WinW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [OpW-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OpW-1:0] OP_READ   = 2'd1;
  localparam logic [OpW-1:0] OP_TICK   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_PPD      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COMP_EN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HALF_THR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REST     = 3'd4;

  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_TRIGGER = 1'b1;

  // delta per {old phase, new phase}, two's complement
  localparam logic [1:0] QUAD_TBL [16] = '{
    2'b00, 2'b01, 2'b11, 2'b00,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b00, 2'b11, 2'b01, 2'b00
  };

  typedef struct packed {
    logic sample;
    logic tick;
    logic div_start;
    logic div_step;
    logic div_finish;
  } cmd_t;

  typedef struct packed {
    logic tick_trig;
  } sts_t;

endpackage

// File: hw/rtl/qdc_if.sv
// ----------------------------------------------------------------------------
// qdc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface qdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       phase_a;
  logic       phase_b;

  modport source (output valid, output operation, output phase_a, output phase_b,
                  input ready);
  modport sink   (input valid, input operation, input phase_a, input phase_b,
                  output ready);
endinterface

interface qdc_out_if;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic signed [7:0] detent_steps;

  modport source (output valid, output result_kind, output detent_steps,
                  input ready);
  modport sink   (input valid, input result_kind, input detent_steps,
                  output ready);
endinterface

// File: hw/rtl/quadrature_detent_counter_core.sv
// ----------------------------------------------------------------------------
// quadrature_detent_counter_core
// 4x quadrature decoder with saturating pulse count, detent reads and
// missed-pulse compensation window.
// ----------------------------------------------------------------------------
// Pin samples and ticks are taken as single items; a tick trigger is valid the next cycle.
// A read result is valid after 8 bit-serial divider steps and one result load,
// which waits for a free output; the next item is taken once back in idle.
// Input is taken while a result waits if that result is taken in the same cycle.
// Reset (async, active low) clears count, window, flags and restores config
// defaults.
module quadrature_detent_counter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qdc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [qdc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  qdc_in_if.sink                           in_if,
  qdc_out_if.source                        out_if
);
  import qdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .operation_i (in_if.operation),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qdc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .phase_a_i      (in_if.phase_a),
    .phase_b_i      (in_if.phase_b),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_kind_o  (out_if.result_kind),
    .detent_steps_o (out_if.detent_steps)
  );

endmodule

// File: hw/rtl/qdc_datapath.sv
// ----------------------------------------------------------------------------
// qdc_datapath
// Config registers, pulse count, window timer, serial detent divider and
// result register.
// ----------------------------------------------------------------------------
module qdc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qdc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [qdc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           phase_a_i,
  input  logic                           phase_b_i,
  input  qdc_pkg::cmd_t                  cmd_i,
  output qdc_pkg::sts_t                  sts_o,
  output logic                           result_kind_o,
  output logic signed [qdc_pkg::CntW-1:0] detent_steps_o
);
  import qdc_pkg::*;

  logic [PpdW-1:0] ppd_cfg_q;
  logic            comp_en_q;
  logic            half_thr_q;
  logic [WinW-1:0] window_q;
  logic [1:0]      rest_q;

  logic [1:0]             last_phase_q, last_phase_d;
  logic signed [CntW-1:0] count_q, count_d;
  logic                   swallow_q, swallow_d;
  logic [WinW-1:0]        win_left_q, win_left_d;
  logic                   win_run_q, win_run_d;

  logic [CntW-1:0] dvd_q, dvd_d;
  logic [PpdW-1:0] rem_q, rem_d;
  logic [CntW-1:0] quo_q, quo_d;
  logic            neg_q, neg_d;

  logic                   kind_q, kind_d;
  logic signed [CntW-1:0] steps_q, steps_d;

  logic [PpdW-1:0]        ppd;
  logic signed [CntW:0]   cnt9, ppd9, thr9, sum9;
  logic [1:0]             delta;
  logic [1:0]             phase;
  logic                   pos_round, neg_round, win_expire;
  logic [CntW-1:0]        trial;
  logic                   ge;
  logic [CntW-1:0]        trial_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppd_cfg_q   <= PpdW'(1);
      comp_en_q   <= 1'b0;
      half_thr_q  <= 1'b0;
      window_q    <= WinW'(5);
      rest_q      <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PPD:       ppd_cfg_q   <= cfg_wdata_i[PpdW-1:0];
        CFG_COMP_EN:   comp_en_q   <= cfg_wdata_i[0];
        CFG_HALF_THR:  half_thr_q  <= cfg_wdata_i[0];
        CFG_WINDOW:    window_q    <= cfg_wdata_i[WinW-1:0];
        CFG_REST:      rest_q      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign ppd   = (ppd_cfg_q == '0) ? PpdW'(1) : ppd_cfg_q;
  assign cnt9  = {count_q[CntW-1], count_q};
  assign ppd9  = {2'b00, ppd};
  assign thr9  = half_thr_q ? {3'b000, ppd[PpdW-1:1]} : '0;
  assign phase = {phase_a_i, phase_b_i};
  assign delta = QUAD_TBL[{last_phase_q, phase}];
  assign sum9  = cnt9 + {{(CntW-1){delta[1]}}, delta};

  assign win_expire = win_run_q && (win_left_q <= WinW'(1));
  assign pos_round  = (cnt9 > thr9) && (cnt9 < ppd9);
  assign neg_round  = (cnt9 < -thr9) && (cnt9 > -ppd9);
  assign sts_o.tick_trig = win_expire && (pos_round || neg_round);

  assign trial     = {rem_q, dvd_q[CntW-1]};
  assign ge        = trial >= {1'b0, ppd};
  assign trial_sub = trial - {1'b0, ppd};

  always_comb begin
    last_phase_d = last_phase_q;
    count_d      = count_q;
    swallow_d    = swallow_q;
    win_left_d   = win_left_q;
    win_run_d    = win_run_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    kind_d       = kind_q;
    steps_d      = steps_q;

    if (cmd_i.sample) begin
      if (comp_en_q) win_run_d = 1'b0;
      if (swallow_q) begin
        swallow_d = 1'b0;
      end else begin
        if (sum9 > 9'sd127) count_d = 8'sd127;
        else if (sum9 < -9'sd128) count_d = -8'sd128;
        else count_d = sum9[CntW-1:0];
        last_phase_d = phase;
        if (comp_en_q) begin
          win_left_d = window_q;
          win_run_d  = 1'b1;
        end
      end
    end

    if (cmd_i.tick && win_run_q) begin
      if (!win_expire) begin
        win_left_d = win_left_q - WinW'(1);
      end else begin
        win_left_d = '0;
        win_run_d  = 1'b0;
        if (pos_round) count_d = {1'b0, ppd};
        else if (neg_round) count_d = -$signed({1'b0, ppd});
        if (pos_round || neg_round) begin
          swallow_d = 1'b1;
          kind_d    = KIND_TRIGGER;
          steps_d   = '0;
        end
      end
    end

    if (cmd_i.div_start) begin
      neg_d = count_q[CntW-1];
      dvd_d = count_q[CntW-1] ? CntW'(-count_q) : CntW'(count_q);
      rem_d = '0;
      quo_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = ge ? trial_sub[PpdW-1:0] : trial[PpdW-1:0];
      quo_d = {quo_q[CntW-2:0], ge};
      dvd_d = {dvd_q[CntW-2:0], 1'b0};
    end

    if (cmd_i.div_finish) begin
      kind_d  = KIND_READ;
      steps_d = neg_q ? -$signed(quo_q) : $signed(quo_q);
      count_d = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
      if (quo_q != '0) last_phase_d = rest_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= 2'd0;
      count_q      <= '0;
      swallow_q    <= 1'b0;
      win_left_q   <= '0;
      win_run_q    <= 1'b0;
    end else begin
      last_phase_q <= last_phase_d;
      count_q      <= count_d;
      swallow_q    <= swallow_d;
      win_left_q   <= win_left_d;
      win_run_q    <= win_run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    kind_q  <= kind_d;
    steps_q <= steps_d;
  end

  assign result_kind_o  = kind_q;
  assign detent_steps_o = steps_q;

endmodule

// File: hw/rtl/qdc_ctrl.sv
// ----------------------------------------------------------------------------
// qdc_ctrl
// Sequencer: accepts items, runs the serial detent divider, owns result valid.
// ----------------------------------------------------------------------------
module qdc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [qdc_pkg::OpW-1:0]  operation_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  qdc_pkg::sts_t            sts_i,
  output qdc_pkg::cmd_t            cmd_o
);
  import qdc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.sample     = accept && (operation_i == OP_SAMPLE);
    cmd_o.tick       = accept && (operation_i == OP_TICK);
    cmd_o.div_start  = accept && (operation_i == OP_READ);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.div_finish = (state_q == S_DONE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.div_start) begin
          state_d = S_DIV;
          step_d  = '0;
        end
      end
      S_DIV: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.div_finish || (cmd_o.tick && sts_i.tick_trig)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
